// ----- rtl/brb_pkg.sv -----
package brb_pkg;

    // Storage geometry
    localparam int DEPTH        = 1024;
    localparam int ADDR_W       = $clog2(DEPTH);
    localparam int CAP_W        = ADDR_W + 1;
    localparam int MAX_TRANSFER = 64;
    localparam int LEN_W        = 7;
    localparam int OP_W         = 2;
    localparam int STATUS_W     = 3;

    // Operation codes of an input transaction
    localparam logic [OP_W-1:0] OP_HEADER = 2'd0;
    localparam logic [OP_W-1:0] OP_BYTE   = 2'd1;
    localparam logic [OP_W-1:0] OP_READ   = 2'd2;
    localparam logic [OP_W-1:0] OP_CLEAR  = 2'd3;

    // Result status codes
    localparam logic [STATUS_W-1:0] ST_OK         = 3'd0;
    localparam logic [STATUS_W-1:0] ST_NOROOM     = 3'd1;
    localparam logic [STATUS_W-1:0] ST_NODATA     = 3'd2;
    localparam logic [STATUS_W-1:0] ST_PENDING    = 3'd3;
    localparam logic [STATUS_W-1:0] ST_UNEXPECTED = 3'd4;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic take_item;
        logic take_cfg;
        logic rd_issue;
        logic rd_load;
    } brb_cmd_t;

    // Status from the datapath to the controller
    typedef struct packed {
        logic burst;
        logic out_free;
        logic rd_last;
    } brb_sts_t;

    // Step a pointer by one and wrap it at the capacity.
    function automatic logic [ADDR_W-1:0] advance(input logic [ADDR_W-1:0] p,
                                                  input logic [CAP_W-1:0] cap);
        logic [CAP_W-1:0] n;
        n = {1'b0, p} + CAP_W'(1);
        return (n >= cap) ? '0 : n[ADDR_W-1:0];
    endfunction

    // Clamp a written capacity to the range 1..DEPTH.
    function automatic logic [CAP_W-1:0] clamp_cap(input logic [CAP_W-1:0] c);
        logic [CAP_W-1:0] r;
        r = c;
        if (c == '0) begin
            r = CAP_W'(1);
        end else if (c > CAP_W'(DEPTH)) begin
            r = CAP_W'(DEPTH);
        end
        return r;
    endfunction

endpackage

// ----- rtl/brb_ctrl.sv -----
module brb_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  brb_pkg::brb_sts_t sts,
    output brb_pkg::brb_cmd_t cmd
);

    typedef enum logic [1:0] {
        IDLE,
        RD_ISSUE,
        RD_WAIT
    } state_t;

    state_t state_reg;
    state_t state_next;

    // Handshakes are only taken while no read burst is running.
    always_comb begin
        cfg_ready     = (state_reg == IDLE);
        s_ready       = (state_reg == IDLE) && !cfg_valid && sts.out_free;
        cmd.take_cfg  = cfg_valid && cfg_ready;
        cmd.take_item = s_valid && s_ready;
        cmd.rd_issue  = (state_reg == RD_ISSUE);
        cmd.rd_load   = (state_reg == RD_WAIT) && sts.out_free;
    end

    // Next state: a successful read runs one issue and one load per byte.
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            IDLE: begin
                if (cmd.take_item && sts.burst) begin
                    state_next = RD_ISSUE;
                end
            end
            RD_ISSUE: begin
                state_next = RD_WAIT;
            end
            RD_WAIT: begin
                if (sts.out_free) begin
                    state_next = sts.rd_last ? IDLE : RD_ISSUE;
                end
            end
            default: begin
                state_next = IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

// ----- rtl/brb_datapath.sv -----
module brb_datapath (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  brb_pkg::brb_cmd_t              cmd,
    output brb_pkg::brb_sts_t              sts,
    input  logic [brb_pkg::CAP_W-1:0]      cfg_capacity,
    input  logic [brb_pkg::OP_W-1:0]       s_op,
    input  logic [brb_pkg::LEN_W-1:0]      s_length,
    input  logic [7:0]                     s_data_byte,
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic [brb_pkg::STATUS_W-1:0]   m_status,
    output logic [7:0]                     m_data_out,
    output logic                           m_data_valid,
    output logic                           m_last,
    output logic [brb_pkg::CAP_W-1:0]      m_fill_level
);

    localparam int ADDR_W = brb_pkg::ADDR_W;
    localparam int CAP_W  = brb_pkg::CAP_W;
    localparam int LEN_W  = brb_pkg::LEN_W;

    // Byte store
    logic [7:0] mem [brb_pkg::DEPTH];
    logic [7:0] rdata_reg;

    // Control registers
    logic [CAP_W-1:0]  cap_reg,  cap_next;
    logic [ADDR_W-1:0] rp_reg,   rp_next;
    logic [ADDR_W-1:0] wp_reg,   wp_next;
    logic [CAP_W-1:0]  fill_reg, fill_next;
    logic [LEN_W-1:0]  pend_reg, pend_next;
    logic [LEN_W-1:0]  rem_reg,  rem_next;
    logic              m_valid_reg, m_valid_next;

    // Output payload registers
    logic [brb_pkg::STATUS_W-1:0] status_reg;
    logic [7:0]                   data_reg;
    logic                         dv_reg;
    logic                         last_reg;
    logic [CAP_W-1:0]             level_reg;

    // Result being loaded this cycle
    logic                         load;
    logic [brb_pkg::STATUS_W-1:0] res_status;
    logic [7:0]                   res_data;
    logic                         res_dv;
    logic                         res_last;
    logic                         mem_we;

    // Request checks
    logic len_too_big;
    logic hdr_no_room;
    logic rd_short;

    always_comb begin
        len_too_big = s_length > LEN_W'(brb_pkg::MAX_TRANSFER);
        hdr_no_room = ({1'b0, fill_reg} + (CAP_W + 1)'(s_length)) > {1'b0, cap_reg};
        rd_short    = len_too_big || (CAP_W'(s_length) > fill_reg);
    end

    always_comb begin
        sts.burst    = (s_op == brb_pkg::OP_READ) && !rd_short && (s_length != '0);
        sts.out_free = !m_valid_reg || m_ready;
        sts.rd_last  = (rem_reg == '0);
    end

    // Next-state logic for pointers, counts and the result register
    always_comb begin
        cap_next   = cap_reg;
        rp_next    = rp_reg;
        wp_next    = wp_reg;
        fill_next  = fill_reg;
        pend_next  = pend_reg;
        rem_next   = rem_reg;
        load       = 1'b0;
        mem_we     = 1'b0;
        res_status = brb_pkg::ST_OK;
        res_data   = '0;
        res_dv     = 1'b0;
        res_last   = 1'b1;

        if (cmd.take_cfg) begin
            // A capacity write also empties the buffer.
            cap_next  = brb_pkg::clamp_cap(cfg_capacity);
            rp_next   = '0;
            wp_next   = '0;
            fill_next = '0;
            pend_next = '0;
        end else if (cmd.take_item) begin
            unique case (s_op)
                brb_pkg::OP_HEADER: begin
                    load = 1'b1;
                    if (pend_reg != '0) begin
                        res_status = brb_pkg::ST_PENDING;
                    end else if (len_too_big || hdr_no_room) begin
                        res_status = brb_pkg::ST_NOROOM;
                    end else begin
                        pend_next = s_length;
                    end
                end
                brb_pkg::OP_BYTE: begin
                    load = 1'b1;
                    if (pend_reg == '0) begin
                        res_status = brb_pkg::ST_UNEXPECTED;
                    end else begin
                        mem_we    = 1'b1;
                        wp_next   = brb_pkg::advance(wp_reg, cap_reg);
                        fill_next = fill_reg + CAP_W'(1);
                        pend_next = pend_reg - LEN_W'(1);
                    end
                end
                brb_pkg::OP_READ: begin
                    if (rd_short) begin
                        load       = 1'b1;
                        res_status = brb_pkg::ST_NODATA;
                    end else if (s_length == '0) begin
                        load = 1'b1;
                    end else begin
                        // The whole burst reports the level after removal.
                        fill_next = fill_reg - CAP_W'(s_length);
                        rem_next  = s_length;
                    end
                end
                brb_pkg::OP_CLEAR: begin
                    load      = 1'b1;
                    rp_next   = '0;
                    wp_next   = '0;
                    fill_next = '0;
                    pend_next = '0;
                end
                default: begin
                    load = 1'b0;
                end
            endcase
        end else if (cmd.rd_issue) begin
            rp_next  = brb_pkg::advance(rp_reg, cap_reg);
            rem_next = rem_reg - LEN_W'(1);
        end else if (cmd.rd_load) begin
            load     = 1'b1;
            res_data = rdata_reg;
            res_dv   = 1'b1;
            res_last = (rem_reg == '0);
        end

        if (load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    // Control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cap_reg     <= CAP_W'(brb_pkg::DEPTH);
            rp_reg      <= '0;
            wp_reg      <= '0;
            fill_reg    <= '0;
            pend_reg    <= '0;
            rem_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            cap_reg     <= cap_next;
            rp_reg      <= rp_next;
            wp_reg      <= wp_next;
            fill_reg    <= fill_next;
            pend_reg    <= pend_next;
            rem_reg     <= rem_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Byte store with a registered read port
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[wp_reg] <= s_data_byte;
        end
        if (cmd.rd_issue) begin
            rdata_reg <= mem[rp_reg];
        end
    end

    // Result payload
    always_ff @(posedge aclk) begin
        if (load) begin
            status_reg <= res_status;
            data_reg   <= res_data;
            dv_reg     <= res_dv;
            last_reg   <= res_last;
            level_reg  <= fill_next;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_status     = status_reg;
    assign m_data_out   = data_reg;
    assign m_data_valid = dv_reg;
    assign m_last       = last_reg;
    assign m_fill_level = level_reg;

endmodule

// ----- rtl/byte_ring_buffer_core.sv -----
// Channel   | Handshake            | Payload
// ----------+----------------------+-------------------------------------------
// config    | cfg_valid/cfg_ready  | cfg_capacity
// input     | s_valid/s_ready      | s_op, s_length, s_data_byte
// result    | m_valid/m_ready      | m_status, m_data_out, m_data_valid, m_last,
//           |                      | m_fill_level
//
// A header, byte, clear, zero-length read or failed read is accepted and gives
// one result.
// A successful read of N bytes is accepted, then for each byte the byte store is
// addressed and its read data is moved to the output once the result side is free.
// Reset (aresetn low, synchronous) empties the buffer and sets capacity to 1024.
// A stalled result holds the input side; a result is taken while the next
// transaction is accepted.
module byte_ring_buffer_core (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [brb_pkg::CAP_W-1:0]    cfg_capacity,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic [brb_pkg::OP_W-1:0]     s_op,
    input  logic [brb_pkg::LEN_W-1:0]    s_length,
    input  logic [7:0]                   s_data_byte,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic [brb_pkg::STATUS_W-1:0] m_status,
    output logic [7:0]                   m_data_out,
    output logic                         m_data_valid,
    output logic                         m_last,
    output logic [brb_pkg::CAP_W-1:0]    m_fill_level
);

    brb_pkg::brb_cmd_t cmd;
    brb_pkg::brb_sts_t sts;

    brb_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    brb_datapath u_dp (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cmd          (cmd),
        .sts          (sts),
        .cfg_capacity (cfg_capacity),
        .s_op         (s_op),
        .s_length     (s_length),
        .s_data_byte  (s_data_byte),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_status     (m_status),
        .m_data_out   (m_data_out),
        .m_data_valid (m_data_valid),
        .m_last       (m_last),
        .m_fill_level (m_fill_level)
    );

endmodule

// ----- rtl/brb_checker.sv -----
module brb_checker (
    input logic                         aclk,
    input logic                         aresetn,
    input logic                         m_valid,
    input logic                         m_ready,
    input logic [brb_pkg::STATUS_W-1:0] m_status,
    input logic [7:0]                   m_data_out,
    input logic                         m_data_valid,
    input logic                         m_last,
    input logic [brb_pkg::CAP_W-1:0]    m_fill_level
);

    // A stalled result transaction keeps its payload.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_status) && $stable(m_data_out)
            && $stable(m_data_valid) && $stable(m_last) && $stable(m_fill_level))
        else $error("result changed while stalled");

    // Read data only comes with an ok status.
    a_data_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data_valid |-> m_status == brb_pkg::ST_OK)
        else $error("read byte with error status");

    // Every result without data is the only result of its transaction.
    a_single: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_data_valid |-> m_last)
        else $error("non-data result without last");

    // The reported level never exceeds the store depth.
    a_level: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_fill_level <= brb_pkg::CAP_W'(brb_pkg::DEPTH))
        else $error("fill level out of range");

endmodule

bind byte_ring_buffer_core brb_checker u_brb_checker (
    .aclk         (aclk),
    .aresetn      (aresetn),
    .m_valid      (m_valid),
    .m_ready      (m_ready),
    .m_status     (m_status),
    .m_data_out   (m_data_out),
    .m_data_valid (m_data_valid),
    .m_last       (m_last),
    .m_fill_level (m_fill_level)
);
